// File: rtl/btr_pkg.sv
// Package for the budget trend regression block: codes, fixed field widths
// and the command bundle from controller to datapath. No dependencies.

package btr_pkg;

  // Fixed widths of the configuration and result fields.
  localparam int unsigned WLEN_W     = 7;
  localparam int unsigned GOAL_W     = 24;
  localparam int unsigned CTG_W      = 10;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_GOAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_TO_GOAL = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;
  localparam logic [GOAL_W-1:0] GOAL_RESET = 24'd0;
  localparam logic [CTG_W-1:0]  CTG_RESET  = 10'd4;

  // Result action codes.
  localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOWER    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INCREASE = 2'd2;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUM_N1,   // value sum times (n+1)
    OP_GOAL_N,   // buffer goal times n
    OP_DEV_N1,   // deviation times (n+1)
    OP_DEV_NSQ,  // deviation times (n*n-1)
    OP_NUM3_C    // 3*numerator times (n-1+2*chunks_to_goal)
  } mul_op_e;

  typedef struct packed {
    logic    push;      // write the accepted value and clear the sums
    logic    rd_en;     // read the next history entry, newest first
    mul_op_e op;
    logic    ld_nsq;
    logic    ld_num;
    logic    ld_dev;
    logic    ld_lhs1;
    logic    ld_lhs2;
    logic    ld_res;
    logic    res_full;
  } btr_cmd_t;

endpackage

// File: rtl/btr_ctrl.sv
// Controller of the budget trend regression block: sequencing state machine,
// window fill count and output valid flag. Depends on btr_pkg.

module btr_ctrl import btr_pkg::*; #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned NW         = $clog2(WINDOW_MAX + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WLEN_W-1:0] window_length_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NW-1:0]     win_len_o,
  output btr_cmd_t          cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_MN    = 4'd3;
  localparam logic [3:0] ST_MD    = 4'd4;
  localparam logic [3:0] ST_M3N   = 4'd5;
  localparam logic [3:0] ST_ML1   = 4'd6;
  localparam logic [3:0] ST_ML2   = 4'd7;
  localparam logic [3:0] ST_MR2   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam logic [NW-1:0] FILL_MAX = NW'(WINDOW_MAX + 1);

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] fill_q, fill_d, fill_next;
  logic [NW-1:0] n_q, n_d, n_clamp;
  logic [NW-1:0] k_q, k_d;
  logic          eval_q, eval_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  // Out-of-range window lengths are clamped to the supported span.
  always_comb begin
    if (window_length_i < WLEN_W'(2)) begin
      n_clamp = NW'(2);
    end else if (32'(window_length_i) > WINDOW_MAX) begin
      n_clamp = NW'(WINDOW_MAX);
    end else begin
      n_clamp = NW'(window_length_i);
    end
  end

  assign fill_next = (fill_q == FILL_MAX) ? fill_q : fill_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    n_d         = n_q;
    k_d         = k_q;
    eval_d      = eval_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          fill_d     = fill_next;
          n_d        = n_clamp;
          k_d        = '0;
          eval_d     = (fill_next > n_clamp);
          state_d    = (fill_next > n_clamp) ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        k_d         = k_q + 1'b1;
        if (k_q == n_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_MN;
      end
      ST_MN: begin
        cmd_o.op     = OP_SUM_N1;
        cmd_o.ld_nsq = 1'b1;
        state_d      = ST_MD;
      end
      ST_MD: begin
        cmd_o.op     = OP_GOAL_N;
        cmd_o.ld_num = 1'b1;
        state_d      = ST_M3N;
      end
      ST_M3N: begin
        cmd_o.ld_dev = 1'b1;
        state_d      = ST_ML1;
      end
      ST_ML1: begin
        cmd_o.op = OP_DEV_N1;
        state_d  = ST_ML2;
      end
      ST_ML2: begin
        cmd_o.op      = OP_DEV_NSQ;
        cmd_o.ld_lhs1 = 1'b1;
        state_d       = ST_MR2;
      end
      ST_MR2: begin
        cmd_o.op      = OP_NUM3_C;
        cmd_o.ld_lhs2 = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        // The result waits here until the output register can take it.
        if (out_free) begin
          cmd_o.ld_res   = 1'b1;
          cmd_o.res_full = eval_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      n_q         <= NW'(2);
      k_q         <= '0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      k_q         <= k_d;
      eval_q      <= eval_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign win_len_o   = n_q;

endmodule

// File: rtl/btr_dpath.sv
// Datapath of the budget trend regression block: history memory, running
// sums, shared multiplier, crossing tests and result register. Depends on btr_pkg.

module btr_dpath import btr_pkg::*; #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned BUDGET_WIDTH = 24,
  parameter int unsigned NW           = $clog2(WINDOW_MAX + 2)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  btr_cmd_t                       cmd_i,
  input  logic [NW-1:0]                  win_len_i,
  input  logic signed [GOAL_W-1:0]       buffer_goal_i,
  input  logic [CTG_W-1:0]               chunks_to_goal_i,
  input  logic signed [BUDGET_WIDTH-1:0] budget_left_i,
  output logic [ACTION_W-1:0]            action_o,
  output logic                           window_full_o
);

  localparam int unsigned AW   = $clog2(WINDOW_MAX);
  localparam int unsigned SW   = BUDGET_WIDTH + NW;
  localparam int unsigned PW   = BUDGET_WIDTH + 2 * NW;
  localparam int unsigned NUMW = PW + 3;
  localparam int unsigned N3W  = NUMW + 2;
  localparam int unsigned GBW  = (GOAL_W > BUDGET_WIDTH) ? GOAL_W : BUDGET_WIDTH;
  localparam int unsigned DW   = GBW + NW + 2;
  localparam int unsigned MAW  = (N3W > DW) ? N3W : DW;
  localparam int unsigned MBW  = 2 * NW + CTG_W;
  localparam int unsigned PRW  = MAW + MBW + 1;

  logic signed [BUDGET_WIDTH-1:0] hist_mem [WINDOW_MAX];
  logic signed [BUDGET_WIDTH-1:0] rdata_q;
  logic [AW-1:0]                  wp_q, rp_q;
  logic                           vld_q;

  logic signed [SW-1:0]   sum_q, sum_d;
  logic signed [PW-1:0]   psum_q;
  logic [2*NW-1:0]        nsq_q;
  logic signed [NUMW-1:0] num_q;
  logic signed [N3W-1:0]  num3_q;
  logic signed [DW-1:0]   dev_q;
  logic signed [PRW-1:0]  prod_q, prod_d;
  logic signed [PRW-1:0]  lhs1_q, lhs2_q;
  logic signed [PRW-1:0]  num_full, dev_full, rhs1;

  logic signed [MAW-1:0]  mul_a;
  logic [MBW-1:0]         mul_b;

  logic                   num_pos, num_zero, near_cross, far_cross;
  logic [ACTION_W-1:0]    action_d, action_q;
  logic                   full_q;

  // History as a circular buffer; reads walk backward from the newest entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_mem[wp_q] <= budget_left_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= hist_mem[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.rd_en;
      if (cmd_i.push) begin
        wp_q <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
        rp_q <= wp_q;
      end else if (cmd_i.rd_en) begin
        rp_q <= (rp_q == '0) ? AW'(WINDOW_MAX - 1) : rp_q - 1'b1;
      end
    end
  end

  // Adding the running sum into the weighted sum after each newest-first value
  // gives the value k places from the newest the weight n-k.
  assign sum_d = sum_q + SW'(rdata_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      sum_q  <= '0;
      psum_q <= '0;
    end else if (vld_q) begin
      sum_q  <= sum_d;
      psum_q <= psum_q + PW'(sum_d);
    end
  end

  // Shared multiplier, signed operand times unsigned operand.
  always_comb begin
    unique case (cmd_i.op)
      OP_SUM_N1: begin
        mul_a = MAW'(sum_q);
        mul_b = MBW'(win_len_i) + MBW'(1);
      end
      OP_GOAL_N: begin
        mul_a = MAW'(buffer_goal_i);
        mul_b = MBW'(win_len_i);
      end
      OP_DEV_N1: begin
        mul_a = MAW'(dev_q);
        mul_b = MBW'(win_len_i) + MBW'(1);
      end
      OP_DEV_NSQ: begin
        mul_a = MAW'(dev_q);
        mul_b = MBW'(nsq_q);
      end
      OP_NUM3_C: begin
        mul_a = MAW'(num3_q);
        mul_b = MBW'(win_len_i) + (MBW'(chunks_to_goal_i) << 1) - MBW'(1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = mul_a * $signed({1'b0, mul_b});
  assign num_full = (PRW'(psum_q) <<< 1) - prod_q;
  assign dev_full = prod_q - PRW'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ld_nsq) begin
      nsq_q <= (2 * NW)'(win_len_i) * (2 * NW)'(win_len_i) - (2 * NW)'(1);
    end
    if (cmd_i.ld_num) begin
      num_q <= num_full[NUMW-1:0];
    end
    if (cmd_i.ld_dev) begin
      dev_q  <= dev_full[DW-1:0];
      num3_q <= N3W'(num_q) + (N3W'(num_q) <<< 1);
    end
    if (cmd_i.ld_lhs1) begin
      lhs1_q <= prod_q;
    end
    if (cmd_i.ld_lhs2) begin
      lhs2_q <= prod_q;
    end
  end

  // Crossing tests; the product register holds the far-side right-hand term
  // while the result is taken.
  assign rhs1       = PRW'(num3_q);
  assign num_zero   = (num_q == '0);
  assign num_pos    = !num_q[NUMW-1] && !num_zero;
  assign near_cross = num_pos ? (lhs1_q < rhs1) : (lhs1_q > rhs1);
  assign far_cross  = num_pos ? (lhs2_q > prod_q) : (lhs2_q < prod_q);

  always_comb begin
    if (!cmd_i.res_full || num_zero) begin
      action_d = ACT_NONE;
    end else if (near_cross) begin
      action_d = num_pos ? ACT_LOWER : ACT_INCREASE;
    end else if (far_cross) begin
      action_d = num_pos ? ACT_INCREASE : ACT_LOWER;
    end else begin
      action_d = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= ACT_NONE;
      full_q   <= 1'b0;
    end else if (cmd_i.ld_res) begin
      action_q <= action_d;
      full_q   <= cmd_i.res_full;
    end
  end

  assign action_o      = action_q;
  assign window_full_o = full_q;

endmodule

// File: rtl/budget_trend_regression.sv
// Top level of the budget trend regression block: configuration registers
// and the controller and datapath. Depends on btr_pkg, btr_ctrl, btr_dpath.

// One budget-left value is taken per transfer and one result comes back for
// each. Until more than n values (n = window_length, clamped to 2..WINDOW_MAX)
// have arrived since reset, the result is action 0 with window_full 0, and
// such an item goes from the idle state straight to the result state.
// Afterward the block fits a least-squares line over the newest n values and
// reports whether it meets buffer_goal too early or too late. For an
// evaluated item the history memory is read one entry per cycle to form the
// sums, and then one shared multiplier forms five products. The result sits
// in an output register, so a stalled output only holds up the end of the
// following item. Configuration writes are accepted at any time and should
// be made while the block is idle.

module budget_trend_regression import btr_pkg::*; #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned BUDGET_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [BUDGET_WIDTH-1:0] budget_left_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ACTION_W-1:0]            action_o,
  output logic                           window_full_o
);

  localparam int unsigned NW = $clog2(WINDOW_MAX + 2);

  logic [WLEN_W-1:0]        wlen_q;
  logic signed [GOAL_W-1:0] goal_q;
  logic [CTG_W-1:0]         ctg_q;
  logic [NW-1:0]            win_len;
  btr_cmd_t                 cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
      goal_q <= GOAL_RESET;
      ctg_q  <= CTG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH:  wlen_q <= cfg_data_i[WLEN_W-1:0];
        CFG_BUFFER_GOAL:    goal_q <= cfg_data_i[GOAL_W-1:0];
        CFG_CHUNKS_TO_GOAL: ctg_q  <= cfg_data_i[CTG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  btr_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .NW         (NW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_length_i (wlen_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .win_len_o       (win_len),
    .cmd_o           (cmd)
  );

  btr_dpath #(
    .WINDOW_MAX   (WINDOW_MAX),
    .BUDGET_WIDTH (BUDGET_WIDTH),
    .NW           (NW)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .win_len_i        (win_len),
    .buffer_goal_i    (goal_q),
    .chunks_to_goal_i (ctg_q),
    .budget_left_i    (budget_left_i),
    .action_o         (action_o),
    .window_full_o    (window_full_o)
  );

endmodule
